/* sv/fpa_pkg.sv */
`timescale 1ns / 1ps
package fpa_pkg;

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_GT       = 4'd4,
        FN_LT       = 4'd5,
        FN_GE       = 4'd6,
        FN_LE       = 4'd7,
        FN_EQ       = 4'd8,
        FN_NE       = 4'd9,
        FN_MIN      = 4'd10,
        FN_MAX      = 4'd11,
        FN_INC      = 4'd12,
        FN_DEC      = 4'd13,
        FN_FROM_INT = 4'd14,
        FN_TO_INT   = 4'd15
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

endpackage

/* sv/fpa_mul.sv */
`timescale 1ns / 1ps
module fpa_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                       i_clk,
    input  logic [DATA_WIDTH-1:0]                      i_mag_a,
    input  logic [DATA_WIDTH-1:0]                      i_mag_b,
    output logic [4*((DATA_WIDTH+1)/2)-1:0]            o_mag
);
    localparam int HW = (DATA_WIDTH + 1) / 2;
    localparam int PW = 4 * HW;

    logic [2*HW-1:0] xe, ye;
    logic [2*HW-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [PW-1:0]   n_sum;
    logic [PW-1:0]   r_mag;

    assign xe = (2*HW)'(i_mag_a);
    assign ye = (2*HW)'(i_mag_b);

    // stage 1: four half-width partial products
    always_ff @(posedge i_clk) begin
        r_p00 <= xe[HW-1:0] * ye[HW-1:0];
        r_p01 <= xe[HW-1:0] * ye[2*HW-1:HW];
        r_p10 <= xe[2*HW-1:HW] * ye[HW-1:0];
        r_p11 <= xe[2*HW-1:HW] * ye[2*HW-1:HW];
    end

    // stage 2: sum, add half lsb, drop fraction bits
    always_comb begin
        n_sum = (PW'(r_p11) << (2*HW)) + (PW'(r_p01) << HW) + (PW'(r_p10) << HW)
              + PW'(r_p00) + (PW'(1) << (FRAC_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_sum >> FRAC_BITS;
    end

    assign o_mag = r_mag;
endmodule

/* sv/fpa_div.sv */
`timescale 1ns / 1ps
module fpa_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                            i_clk,
    input  logic [DATA_WIDTH-1:0]           i_num,
    input  logic [DATA_WIDTH-1:0]           i_den,
    output logic [DATA_WIDTH+FRAC_BITS-1:0] o_quo,
    output logic [DATA_WIDTH-1:0]           o_rem,
    output logic [DATA_WIDTH-1:0]           o_den
);
    localparam int W  = DATA_WIDTH;
    localparam int QW = DATA_WIDTH + FRAC_BITS;

    logic [QW-1:0] r_n [QW];
    logic [QW-1:0] r_q [QW];
    logic [W-1:0]  r_r [QW];
    logic [W-1:0]  r_d [QW];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [QW-1:0] p_n, p_q;
        logic [W-1:0]  p_r, p_d;
        logic [W:0]    rt;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_n = {i_num, {FRAC_BITS{1'b0}}};
            assign p_q = '0;
            assign p_r = '0;
            assign p_d = i_den;
        end else begin : g_next
            assign p_n = r_n[k-1];
            assign p_q = r_q[k-1];
            assign p_r = r_r[k-1];
            assign p_d = r_d[k-1];
        end

        assign rt = {p_r, p_n[QW-1]};
        assign ge = rt >= {1'b0, p_d};

        always_ff @(posedge i_clk) begin
            r_n[k] <= p_n << 1;
            r_q[k] <= {p_q[QW-2:0], ge};
            r_r[k] <= ge ? W'(rt - {1'b0, p_d}) : W'(rt);
            r_d[k] <= p_d;
        end
    end

    assign o_quo = r_q[QW-1];
    assign o_rem = r_r[QW-1];
    assign o_den = r_d[QW-1];
endmodule

/* sv/fixed_point_alu_q24_8.sv */
`timescale 1ns / 1ps
// Signed fixed-point ALU (DATA_WIDTH bits, FRAC_BITS fraction). A transaction is taken on
// every cycle with start high; busy is tied low because the datapath is fully pipelined
// and the receiver cannot stall. Every operation has the same latency: its result strobes
// on o_valid after a delay line that matches the restoring divider, which resolves one
// quotient bit per pipeline stage. Results keep transaction order; mul and div round half
// away from zero and all overflow saturates.
module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   i_func,
    input  logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [DATA_WIDTH-1:0] i_operand_b,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_result_value,
    output logic                         o_compare_true,
    output logic [1:0]                   o_status
);
    import fpa_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int QW = DATA_WIDTH + FRAC_BITS;
    localparam int HW = (DATA_WIDTH + 1) / 2;
    localparam int PW = 4 * HW;
    localparam int MW = (PW > QW + 1) ? PW : QW + 1;

    localparam logic signed [W-1:0] MAXS = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINS = {1'b1, {(W-1){1'b0}}};
    localparam logic [MW-1:0] LIM_P = (MW'(1) << (W-1)) - MW'(1);
    localparam logic [MW-1:0] LIM_N = MW'(1) << (W-1);

    typedef struct packed {
        logic          valid;
        t_func         func;
        logic [W-1:0]  simp;
        logic          cmp;
        logic          sat;
        logic          neg;
        logic [PW-1:0] mag;
    } t_pipe;

    logic                r_s0_valid;
    t_func               r_s0_func;
    logic signed [W-1:0] r_s0_a, r_s0_b;

    t_pipe               r_pipe [QW];
    t_pipe               n_p0;
    t_pipe               n_p2;

    logic [W-1:0]        mag_a, mag_b;
    logic [PW-1:0]       mul_mag;
    logic [QW-1:0]       div_quo;
    logic [W-1:0]        div_rem, div_den;

    logic                r_valid, r_cmp;
    logic [W-1:0]        r_res;
    t_status             r_status;
    logic                n_valid, n_cmp;
    logic [W-1:0]        n_res;
    t_status             n_status;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
        r_s0_func <= t_func'(i_func);
        r_s0_a    <= i_operand_a;
        r_s0_b    <= i_operand_b;
    end

    assign mag_a = r_s0_a[W-1] ? W'(-r_s0_a) : W'(r_s0_a);
    assign mag_b = r_s0_b[W-1] ? W'(-r_s0_b) : W'(r_s0_b);

    fpa_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_mag_a (mag_a),
        .i_mag_b (mag_b),
        .o_mag   (mul_mag)
    );

    fpa_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk (i_clk),
        .i_num (mag_a),
        .i_den (mag_b),
        .o_quo (div_quo),
        .o_rem (div_rem),
        .o_den (div_den)
    );

    // combinational ops, carried down the delay line beside mul and div
    always_comb begin
        logic signed [W:0]   s;
        logic signed [W:0]   bx;
        logic                lt, gt, eq;
        s  = '0;
        bx = {r_s0_b[W-1], r_s0_b};
        lt = r_s0_a < r_s0_b;
        gt = r_s0_b < r_s0_a;
        eq = r_s0_a == r_s0_b;

        n_p0       = '0;
        n_p0.valid = r_s0_valid;
        n_p0.func  = r_s0_func;
        n_p0.neg   = r_s0_a[W-1] ^ r_s0_b[W-1];

        if (r_s0_func == FN_INC || r_s0_func == FN_DEC) begin
            bx = (W+1)'(1);
        end
        if (r_s0_func == FN_SUB || r_s0_func == FN_DEC) begin
            s = {r_s0_a[W-1], r_s0_a} - bx;
        end else begin
            s = {r_s0_a[W-1], r_s0_a} + bx;
        end

        case (r_s0_func)
            FN_ADD, FN_SUB, FN_INC, FN_DEC: begin
                if (s[W] != s[W-1]) begin
                    n_p0.sat  = 1'b1;
                    n_p0.simp = s[W] ? MINS : MAXS;
                end else begin
                    n_p0.simp = s[W-1:0];
                end
            end
            FN_GT:  n_p0.cmp = gt;
            FN_LT:  n_p0.cmp = lt;
            FN_GE:  n_p0.cmp = !lt;
            FN_LE:  n_p0.cmp = !gt;
            FN_EQ:  n_p0.cmp = eq;
            FN_NE:  n_p0.cmp = !eq;
            FN_MIN: n_p0.simp = lt ? r_s0_a : r_s0_b;
            FN_MAX: n_p0.simp = gt ? r_s0_a : r_s0_b;
            FN_FROM_INT: begin
                if (r_s0_a > (MAXS >>> FRAC_BITS)) begin
                    n_p0.sat  = 1'b1;
                    n_p0.simp = MAXS;
                end else if (r_s0_a < (MINS >>> FRAC_BITS)) begin
                    n_p0.sat  = 1'b1;
                    n_p0.simp = MINS;
                end else begin
                    n_p0.simp = r_s0_a <<< FRAC_BITS;
                end
            end
            FN_TO_INT: n_p0.simp = r_s0_a >>> FRAC_BITS;
            default: ;
        endcase
    end

    // mul magnitude leaves the mul product register in step with r_pipe[1]
    always_comb begin
        n_p2     = r_pipe[1];
        n_p2.mag = mul_mag;
    end

    // delay line; mul magnitude joins at the third stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_pipe[k].valid <= 1'b0;
            end
        end else begin
            r_pipe[0] <= n_p0;
            r_pipe[1] <= r_pipe[0];
            r_pipe[2] <= n_p2;
            for (int k = 3; k < QW; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    // final stage: round quotient, flag divide by zero, saturate magnitude, restore sign
    always_comb begin
        logic [MW-1:0] m;
        logic          rnd;
        t_pipe         p;
        p   = r_pipe[QW-1];
        rnd = {div_rem, 1'b0} >= {1'b0, div_den};
        m   = (p.func == FN_DIV) ? MW'(div_quo) + MW'(rnd) : MW'(p.mag);

        n_valid  = p.valid;
        n_cmp    = p.cmp;
        n_res    = p.simp;
        n_status = p.sat ? ST_SAT : ST_OK;

        if (p.func == FN_DIV && div_den == '0) begin
            n_res    = '0;
            n_status = ST_DIV0;
        end else if (p.func == FN_MUL || p.func == FN_DIV) begin
            if (!p.neg && m > LIM_P) begin
                n_res    = MAXS;
                n_status = ST_SAT;
            end else if (p.neg && m > LIM_N) begin
                n_res    = MINS;
                n_status = ST_SAT;
            end else begin
                n_res = p.neg ? W'(-m[W-1:0]) : m[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_res    <= n_res;
        r_cmp    <= n_cmp;
        r_status <= n_status;
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_res;
    assign o_compare_true = r_cmp;
    assign o_status       = r_status;
endmodule
